// ===== rtl/core/trsc_pkg.sv =====
`timescale 1ns / 1ps

package trsc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int ROTOR_COUNT   = 3;

  // Fixed field widths of the item ports.
  localparam int SEL_W  = 2;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 5;
  localparam int BYTE_W = 8;

  // Width of a reduced table index and of the unreduced index sum.
  localparam int IDX_W     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int SUM_W     = VAL_W + 1;
  localparam int SUM_DEPTH = 1 << SUM_W;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'd65;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'd122;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_CIPHER = 1'b1
  } trsc_req_t;

  // One table write toward a rotor.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } trsc_wr_t;

  typedef logic [SUM_DEPTH-1:0][IDX_W-1:0] trsc_mod_tab_t;

  // Residue of every possible index sum, worked out at elaboration.
  function automatic trsc_mod_tab_t build_mod_table();
    trsc_mod_tab_t tab;
    for (int i = 0; i < SUM_DEPTH; i++) begin
      tab[i] = IDX_W'(i % ALPHABET_SIZE);
    end
    return tab;
  endfunction

  localparam trsc_mod_tab_t MOD_TABLE = build_mod_table();

endpackage

// ===== rtl/core/trsc_rotor.sv =====
`timescale 1ns / 1ps

module trsc_rotor
  import trsc_pkg::*;
(
  input  logic             clk,
  input  trsc_wr_t         wr,
  input  logic [VAL_W-1:0] in_val,
  input  logic [IDX_W-1:0] offset,
  output logic [VAL_W-1:0] out_val
);

  logic [VAL_W-1:0] table_r [ALPHABET_SIZE];
  logic [SUM_W-1:0] idx_sum;
  logic [IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      table_r[wr.pos] <= wr.value;
    end
  end

  // The stored value may exceed the alphabet, so the whole sum is reduced.
  assign idx_sum = SUM_W'(in_val) + SUM_W'(offset);
  assign idx     = MOD_TABLE[idx_sum];
  assign out_val = table_r[idx];

endmodule

// ===== rtl/core/three_rotor_substitution_cipher_top.sv =====
`timescale 1ns / 1ps

// Three-rotor substitution cipher. Each transaction on the in_ channel either
// loads one rotor table entry (in_req_type 0) or ciphers one byte (1). A
// cipher transaction yields exactly one out_ transaction: letters go through
// rotors 0, 1 and 2 with the rotor offsets and keep their case; other bytes
// are copied unchanged. A load yields nothing. One transaction is taken every
// clock cycle while the result side does not stall. A transaction waits in
// the input register until the output register is free; a cipher result
// then moves to the output register, which presents it. The cycle is set by
// the three chained table reads, each with its offset add and residue lookup.
// The rotor tables are not cleared by reset: load every entry that a message
// will touch before ciphering it. Offsets reset to zero and advance like an
// odometer after each letter.

module three_rotor_substitution_cipher_top
  import trsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [SEL_W-1:0]  in_rotor_sel,
  input  logic [POS_W-1:0]  in_entry_pos,
  input  logic [VAL_W-1:0]  in_entry_value,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte
);

  localparam logic [POS_W:0]   POS_LIMIT = (POS_W + 1)'(ALPHABET_SIZE);
  localparam logic [IDX_W-1:0] OFF_LAST  = IDX_W'(ALPHABET_SIZE - 1);

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_req_r;
  logic [SEL_W-1:0]  s1_sel_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [VAL_W-1:0]  s1_val_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;

  logic [IDX_W-1:0]  offset_r   [ROTOR_COUNT];
  logic [IDX_W-1:0]  offset_nxt [ROTOR_COUNT];
  logic [ROTOR_COUNT:0] carry;

  logic [VAL_W-1:0]  chain [ROTOR_COUNT+1];
  trsc_wr_t          wr    [ROTOR_COUNT];

  logic              in_accept;
  logic              out_free;
  logic              s1_fire;
  logic              is_upper;
  logic              is_lower;
  logic              is_letter;
  logic              pos_ok;
  logic [BYTE_W-1:0] case_base;
  logic [BYTE_W-1:0] result_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r  <= in_req_type;
      s1_sel_r  <= in_rotor_sel;
      s1_pos_r  <= in_entry_pos;
      s1_val_r  <= in_entry_value;
      s1_byte_r <= in_byte;
    end
  end

  assign is_upper  = (s1_byte_r >= CHAR_UPPER_A) && (s1_byte_r <= CHAR_UPPER_Z);
  assign is_lower  = (s1_byte_r >= CHAR_LOWER_A) && (s1_byte_r <= CHAR_LOWER_Z);
  assign is_letter = is_upper || is_lower;
  assign case_base = is_upper ? CHAR_UPPER_A : CHAR_LOWER_A;
  assign pos_ok    = {1'b0, s1_pos_r} < POS_LIMIT;

  assign chain[0] = VAL_W'(s1_byte_r - case_base);

  for (genvar r = 0; r < ROTOR_COUNT; r++) begin : g_rotor
    assign wr[r].en    = s1_fire && (s1_req_r == REQ_LOAD) && pos_ok &&
                         (s1_sel_r == SEL_W'(r));
    assign wr[r].pos   = s1_pos_r[IDX_W-1:0];
    assign wr[r].value = s1_val_r;

    trsc_rotor u_rotor (
      .clk     (clk),
      .wr      (wr[r]),
      .in_val  (chain[r]),
      .offset  (offset_r[r]),
      .out_val (chain[r+1])
    );
  end

  // Odometer: each rotor steps only when every rotor before it wraps.
  always_comb begin
    carry[0] = s1_fire && (s1_req_r == REQ_CIPHER) && is_letter;
    for (int r = 0; r < ROTOR_COUNT; r++) begin
      offset_nxt[r] = offset_r[r];
      if (carry[r]) begin
        offset_nxt[r] = (offset_r[r] == OFF_LAST) ? '0 : offset_r[r] + 1'b1;
      end
      carry[r+1] = carry[r] && (offset_r[r] == OFF_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROTOR_COUNT; r++) begin
        offset_r[r] <= '0;
      end
    end else begin
      for (int r = 0; r < ROTOR_COUNT; r++) begin
        offset_r[r] <= offset_nxt[r];
      end
    end
  end

  assign result_byte = is_letter ? BYTE_W'(chain[ROTOR_COUNT]) + case_base : s1_byte_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && (s1_req_r == REQ_CIPHER)) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_req_r == REQ_CIPHER)) begin
      out_byte_r <= result_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

endmodule
